@@ hdl/ntpd_pkg.sv @@
// shared types, constants and helpers of the two-phase nodal drag update
package ntpd_pkg;

  // largest unsigned q16.16 magnitude kept in 31 bits
  localparam logic [30:0] CAP31 = 31'h7FFF_FFFF;
  // hold value of a velocity increment magnitude (2^33)
  localparam logic [33:0] DELTA_CAP = 34'h2_0000_0000;
  // cell volume after reset, 1.0 in q16.16
  localparam logic [30:0] CELL_VOLUME_RST = 31'd65536;

  typedef enum logic [1:0] {
    REG_CELL_VOLUME    = 2'd0,
    REG_INTERACTION_MU = 2'd1,
    REG_TIME_STEP      = 2'd2,
    REG_USE_SVF        = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [16:0]        node_weight;
    logic [30:0]        volume_a;
    logic [30:0]        volume_b;
    logic [30:0]        mass_a;
    logic [30:0]        mass_b;
    logic signed [31:0] vel_a_x;
    logic signed [31:0] vel_a_y;
    logic signed [31:0] vel_a_z;
    logic signed [31:0] vel_b_x;
    logic signed [31:0] vel_b_y;
    logic signed [31:0] vel_b_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] new_vel_a_x;
    logic signed [31:0] new_vel_a_y;
    logic signed [31:0] new_vel_a_z;
    logic signed [31:0] new_vel_b_x;
    logic signed [31:0] new_vel_b_y;
    logic signed [31:0] new_vel_b_z;
    logic               saturated;
  } out_t;

  // clip to 31 bits, msb of the result flags the clip
  function automatic logic [31:0] cap31(input logic [47:0] v);
    logic ovf;
    ovf = |v[47:31];
    return {ovf, ovf ? CAP31 : v[30:0]};
  endfunction

endpackage

@@ hdl/ntpd_div.sv @@
// pipelined restoring divider, one quotient bit per stage, several lanes
module ntpd_div #(
  parameter int unsigned HI_W   = 20,
  parameter int unsigned LO_W   = 31,
  parameter int unsigned DEN_W  = 31,
  parameter int unsigned LANES  = 2,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [HI_W-1:0]   hi_i   [LANES],
  input  logic [LO_W-1:0]   lo_i   [LANES],
  input  logic [DEN_W-1:0]  den_i  [LANES],
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [LO_W-1:0]   quo_o  [LANES],
  output logic              ovf_o  [LANES],
  output logic [SIDE_W-1:0] side_o
);

  // load stage plus one stage per quotient bit; hi must not be wider than den
  localparam int unsigned NS = LO_W + 1;

  logic              vld_q  [NS];
  logic              vld_d  [NS];
  logic [DEN_W-1:0]  rem_q  [NS][LANES];
  logic [DEN_W-1:0]  rem_d  [NS][LANES];
  logic [LO_W-1:0]   lq_q   [NS][LANES];
  logic [LO_W-1:0]   lq_d   [NS][LANES];
  logic [DEN_W-1:0]  den_q  [NS][LANES];
  logic [DEN_W-1:0]  den_d  [NS][LANES];
  logic              ovf_q  [NS][LANES];
  logic              ovf_d  [NS][LANES];
  logic [SIDE_W-1:0] side_q [NS];
  logic [SIDE_W-1:0] side_d [NS];

  always_comb begin
    logic [DEN_W:0] trial;
    logic           ge;
    vld_d[0]  = valid_i;
    side_d[0] = side_i;
    for (int l = 0; l < LANES; l++) begin
      rem_d[0][l] = DEN_W'(hi_i[l]);
      lq_d[0][l]  = lo_i[l];
      den_d[0][l] = den_i[l];
      ovf_d[0][l] = DEN_W'(hi_i[l]) >= den_i[l];
    end
    for (int s = 1; s < NS; s++) begin
      vld_d[s]  = vld_q[s-1];
      side_d[s] = side_q[s-1];
      for (int l = 0; l < LANES; l++) begin
        // shift in the next numerator bit, subtract when it fits
        trial       = {rem_q[s-1][l], lq_q[s-1][l][LO_W-1]};
        ge          = trial >= {1'b0, den_q[s-1][l]};
        rem_d[s][l] = ge ? DEN_W'(trial - {1'b0, den_q[s-1][l]}) : trial[DEN_W-1:0];
        lq_d[s][l]  = {lq_q[s-1][l][LO_W-2:0], ge};
        den_d[s][l] = den_q[s-1][l];
        ovf_d[s][l] = ovf_q[s-1][l];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NS; s++) begin
        vld_q[s] <= 1'b0;
      end
    end else if (en_i) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      lq_q   <= lq_d;
      den_q  <= den_d;
      ovf_q  <= ovf_d;
      side_q <= side_d;
    end
  end

  assign valid_o = vld_q[NS-1];
  assign side_o  = side_q[NS-1];
  assign quo_o   = lq_q[NS-1];
  assign ovf_o   = ovf_q[NS-1];

endmodule

@@ hdl/nodal_two_phase_drag_update.sv @@
// top level of the two-phase nodal drag update pipeline
//
//  channel | signals                                  | beat
//  --------+------------------------------------------+------------------------------
//  in      | in_valid_i, in_ready_o, in_data_i        | one grid node (ntpd_pkg::in_t)
//  out     | out_valid_o, out_ready_i, out_data_o     | updated velocities, clip flag
//  cfg     | cfg_valid_i, cfg_ready_o, cfg_index_i,   | one register write
//          | cfg_data_i                               |
//
// one node per cycle is taken while the output buffer has a free entry. the pipeline
// depth is made up of the two bit-per-stage dividers (volume fraction, 32 stages;
// velocity increment, 35 stages) plus the capture, product and multiplier stages.
// reset clears the valid bits and the output buffer; config resets to 0, cell volume 1.0.
// the whole pipe advances together; a two-beat output buffer keeps taking nodes while
// a result waits, and the pipe holds only when both entries are occupied.
module nodal_two_phase_drag_update (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ntpd_pkg::in_t       in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ntpd_pkg::out_t      out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  ntpd_pkg::cfg_reg_e  cfg_index_i,
  input  logic [31:0]         cfg_data_i
);

  // volume fraction divider: 51-bit numerator over the 31-bit cell volume
  localparam int unsigned SVF_HI_W  = 20;
  localparam int unsigned SVF_Q_W   = 31;
  localparam int unsigned SVF_DEN_W = 31;
  // increment divider: (force*dt) << 16 over 8*weight*mass, 34-bit quotient
  localparam int unsigned DEL_HI_W  = 44;
  localparam int unsigned DEL_Q_W   = 34;
  localparam int unsigned DEL_DEN_W = 51;
  localparam int unsigned DEL_LANES = 6;

  // what travels beside the volume fraction divider and the multiplier stages
  typedef struct packed {
    logic             sat;
    logic             svf;
    logic             act_bb;
    logic [30:0]      coeff;
    logic [30:0]      dt;
    logic [50:0]      den_a;
    logic [50:0]      den_b;
    logic [2:0][31:0] mag;
    logic [2:0]       neg;
    logic [2:0][31:0] va;
    logic [2:0][31:0] vb;
  } mid_t;

  // what travels beside the increment divider
  typedef struct packed {
    logic             sat;
    logic             dz_a;
    logic             dz_b;
    logic [2:0]       neg;
    logic [2:0][31:0] va;
    logic [2:0][31:0] vb;
  } tail_t;

  localparam int unsigned MID_W  = $bits(mid_t);
  localparam int unsigned TAIL_W = $bits(tail_t);

  // add a signed increment, saturate to 32 bits; msb flags the clip
  function automatic logic [32:0] sat_add(input logic [31:0] v, input logic [33:0] dm,
                                          input logic sub);
    logic signed [35:0] s;
    logic signed [35:0] d;
    logic               hi;
    logic               lo;
    d  = $signed({2'b00, dm});
    s  = $signed({{4{v[31]}}, v}) + (sub ? -d : d);
    hi = s > 36'sd2147483647;
    lo = s < -36'sd2147483648;
    return {hi | lo, hi ? 32'h7FFF_FFFF : (lo ? 32'h8000_0000 : s[31:0])};
  endfunction

  // ---------------------------------------------------------------- configuration
  logic [30:0] cell_volume_q;
  logic [30:0] interaction_mu_q;
  logic [30:0] time_step_q;
  logic        use_svf_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_volume_q    <= ntpd_pkg::CELL_VOLUME_RST;
      interaction_mu_q <= '0;
      time_step_q      <= '0;
      use_svf_q        <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ntpd_pkg::REG_CELL_VOLUME:    cell_volume_q    <= cfg_data_i[30:0];
        ntpd_pkg::REG_INTERACTION_MU: interaction_mu_q <= cfg_data_i[30:0];
        ntpd_pkg::REG_TIME_STEP:      time_step_q      <= cfg_data_i[30:0];
        ntpd_pkg::REG_USE_SVF:        use_svf_q        <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- flow control
  logic       adv;
  logic [1:0] fifo_cnt_q;

  // whole pipe moves while the output buffer has a free entry
  assign adv        = fifo_cnt_q != 2'd2;
  assign in_ready_o = adv;

  // ---------------------------------------------------------------- stage a: capture
  logic          a_vld_q;
  ntpd_pkg::in_t a_in_q;
  logic [30:0]   a_vcell_q;
  logic [30:0]   a_mu_q;
  logic [30:0]   a_dt_q;
  logic          a_svf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (adv) begin
      a_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_in_q    <= in_data_i;
      // zero cell volume counts as one lsb
      a_vcell_q <= (cell_volume_q == '0) ? 31'd1 : cell_volume_q;
      a_mu_q    <= interaction_mu_q;
      a_dt_q    <= time_step_q;
      a_svf_q   <= use_svf_q;
    end
  end

  // ---------------------------------------------------------------- stage b: products
  logic             b_vld_q;
  logic [61:0]      b_cprod_q;
  logic [50:0]      b_num_a_q;
  logic [50:0]      b_num_b_q;
  logic [50:0]      b_den_a_q;
  logic [50:0]      b_den_b_q;
  logic [30:0]      b_vcell_q;
  logic [30:0]      b_dt_q;
  logic             b_svf_q;
  logic             b_act_q;
  logic [2:0][31:0] b_mag_q;
  logic [2:0]       b_neg_q;
  logic [2:0][31:0] b_va_q;
  logic [2:0][31:0] b_vb_q;

  logic [2:0][31:0] b_va_d;
  logic [2:0][31:0] b_vb_d;
  logic [2:0][31:0] b_mag_d;
  logic [2:0]       b_neg_d;

  always_comb begin
    logic [32:0] dd;
    b_va_d = {a_in_q.vel_a_z, a_in_q.vel_a_y, a_in_q.vel_a_x};
    b_vb_d = {a_in_q.vel_b_z, a_in_q.vel_b_y, a_in_q.vel_b_x};
    for (int d = 0; d < 3; d++) begin
      // velocity difference b - a, kept as sign and magnitude
      dd         = {b_vb_d[d][31], b_vb_d[d]} - {b_va_d[d][31], b_va_d[d]};
      b_neg_d[d] = dd[32];
      b_mag_d[d] = dd[32] ? 32'(-dd) : dd[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (adv) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_cprod_q <= 62'(a_vcell_q) * 62'(a_mu_q);
      b_num_a_q <= {48'(a_in_q.node_weight) * 48'(a_in_q.volume_a), 3'b000};
      b_num_b_q <= {48'(a_in_q.node_weight) * 48'(a_in_q.volume_b), 3'b000};
      b_den_a_q <= {48'(a_in_q.node_weight) * 48'(a_in_q.mass_a), 3'b000};
      b_den_b_q <= {48'(a_in_q.node_weight) * 48'(a_in_q.mass_b), 3'b000};
      b_vcell_q <= a_vcell_q;
      b_dt_q    <= a_dt_q;
      b_svf_q   <= a_svf_q;
      b_act_q   <= (a_in_q.mass_a != '0) && (a_in_q.mass_b != '0);
      b_mag_q   <= b_mag_d;
      b_neg_q   <= b_neg_d;
      b_va_q    <= b_va_d;
      b_vb_q    <= b_vb_d;
    end
  end

  // ---------------------------------------------------------------- volume fractions
  mid_t                 c_mid;
  logic [31:0]          c_coeff;
  logic [SVF_HI_W-1:0]  d1_hi  [2];
  logic [SVF_Q_W-1:0]   d1_lo  [2];
  logic [SVF_DEN_W-1:0] d1_den [2];
  logic                 d1_vld;
  logic [SVF_Q_W-1:0]   d1_quo [2];
  logic                 d1_ovf [2];
  logic [MID_W-1:0]     d1_side;

  always_comb begin
    // coefficient cell_volume*mu, clipped
    c_coeff      = ntpd_pkg::cap31(48'(b_cprod_q[61:16]));
    c_mid.sat    = c_coeff[31];
    c_mid.coeff  = c_coeff[30:0];
    c_mid.svf    = b_svf_q;
    c_mid.act_bb = b_act_q;
    c_mid.dt     = b_dt_q;
    c_mid.den_a  = b_den_a_q;
    c_mid.den_b  = b_den_b_q;
    c_mid.mag    = b_mag_q;
    c_mid.neg    = b_neg_q;
    c_mid.va     = b_va_q;
    c_mid.vb     = b_vb_q;
    d1_hi[0]     = b_num_a_q[50:31];
    d1_lo[0]     = b_num_a_q[30:0];
    d1_hi[1]     = b_num_b_q[50:31];
    d1_lo[1]     = b_num_b_q[30:0];
    d1_den[0]    = b_vcell_q;
    d1_den[1]    = b_vcell_q;
  end

  ntpd_div #(
    .HI_W   (SVF_HI_W),
    .LO_W   (SVF_Q_W),
    .DEN_W  (SVF_DEN_W),
    .LANES  (2),
    .SIDE_W (MID_W)
  ) u_svf_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (b_vld_q),
    .hi_i    (d1_hi),
    .lo_i    (d1_lo),
    .den_i   (d1_den),
    .side_i  (c_mid),
    .valid_o (d1_vld),
    .quo_o   (d1_quo),
    .ovf_o   (d1_ovf),
    .side_o  (d1_side)
  );

  // ---------------------------------------------------------------- stage d: coeff*svf_b
  mid_t        d_mid_d;
  logic [30:0] d_svf_a;
  logic [30:0] d_svf_b;
  logic        d_vld_q;
  mid_t        d_mid_q;
  logic [30:0] d_svf_a_q;
  logic [61:0] d_prod_q;

  always_comb begin
    d_mid_d     = mid_t'(d1_side);
    // fractions above the 31-bit range are clipped
    d_svf_a     = d1_ovf[0] ? ntpd_pkg::CAP31 : d1_quo[0];
    d_svf_b     = d1_ovf[1] ? ntpd_pkg::CAP31 : d1_quo[1];
    d_mid_d.sat = d_mid_d.sat | (d_mid_d.svf & (d1_ovf[0] | d1_ovf[1]));
  end

  // ---------------------------------------------------------------- stage e: *svf_a
  logic [31:0] e_f1;
  mid_t        e_mid_d;
  logic        e_vld_q;
  mid_t        e_mid_q;
  logic [61:0] e_prod_q;

  always_comb begin
    e_f1        = ntpd_pkg::cap31(48'(d_prod_q[61:16]));
    e_mid_d     = d_mid_q;
    e_mid_d.sat = d_mid_q.sat | (d_mid_q.svf & e_f1[31]);
  end

  // ---------------------------------------------------------------- stage f: factor*|dv|
  logic [31:0] f_f2;
  logic [30:0] f_fac;
  mid_t        f_mid_d;
  logic        f_vld_q;
  mid_t        f_mid_q;
  logic        f_act_q;
  logic [2:0][62:0] f_prod_q;

  always_comb begin
    f_f2        = ntpd_pkg::cap31(48'(e_prod_q[61:16]));
    // bang-bang mode uses the coefficient as it is
    f_fac       = e_mid_q.svf ? f_f2[30:0] : e_mid_q.coeff;
    f_mid_d     = e_mid_q;
    f_mid_d.sat = e_mid_q.sat | (e_mid_q.svf & f_f2[31]);
  end

  // ---------------------------------------------------------------- stage g: force*dt
  logic [2:0][30:0] g_force;
  logic             g_sat;
  mid_t             g_mid_d;
  logic             g_vld_q;
  mid_t             g_mid_q;
  logic [2:0][61:0] g_p_q;

  always_comb begin
    logic [31:0] fc;
    logic        live;
    g_sat = f_mid_q.sat;
    for (int d = 0; d < 3; d++) begin
      // no drag when inactive or when the velocities already agree
      live       = f_act_q && (f_mid_q.mag[d] != '0);
      fc         = ntpd_pkg::cap31(48'(f_prod_q[d][62:16]));
      g_force[d] = live ? fc[30:0] : '0;
      g_sat      = g_sat | (live & fc[31]);
    end
    g_mid_d     = f_mid_q;
    g_mid_d.sat = g_sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
      e_vld_q <= 1'b0;
      f_vld_q <= 1'b0;
      g_vld_q <= 1'b0;
    end else if (adv) begin
      d_vld_q <= d1_vld;
      e_vld_q <= d_vld_q;
      f_vld_q <= e_vld_q;
      g_vld_q <= f_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_mid_q   <= d_mid_d;
      d_svf_a_q <= d_svf_a;
      d_prod_q  <= 62'(d_mid_d.coeff) * 62'(d_svf_b);
      e_mid_q   <= e_mid_d;
      e_prod_q  <= 62'(e_f1[30:0]) * 62'(d_svf_a_q);
      f_mid_q   <= f_mid_d;
      f_act_q   <= e_mid_q.svf | e_mid_q.act_bb;
      for (int d = 0; d < 3; d++) begin
        f_prod_q[d] <= 63'(f_fac) * 63'(e_mid_q.mag[d]);
      end
      g_mid_q   <= g_mid_d;
      for (int d = 0; d < 3; d++) begin
        g_p_q[d] <= 62'(g_force[d]) * 62'(f_mid_q.dt);
      end
    end
  end

  // ---------------------------------------------------------------- increments
  tail_t                h_tail;
  logic [DEL_HI_W-1:0]  d2_hi  [DEL_LANES];
  logic [DEL_Q_W-1:0]   d2_lo  [DEL_LANES];
  logic [DEL_DEN_W-1:0] d2_den [DEL_LANES];
  logic                 d2_vld;
  logic [DEL_Q_W-1:0]   d2_quo [DEL_LANES];
  logic                 d2_ovf [DEL_LANES];
  logic [TAIL_W-1:0]    d2_side;

  always_comb begin
    h_tail.sat  = g_mid_q.sat;
    h_tail.dz_a = g_mid_q.den_a == '0;
    h_tail.dz_b = g_mid_q.den_b == '0;
    h_tail.neg  = g_mid_q.neg;
    h_tail.va   = g_mid_q.va;
    h_tail.vb   = g_mid_q.vb;
    // lanes 0..2 phase a x/y/z, lanes 3..5 phase b x/y/z
    for (int d = 0; d < 3; d++) begin
      d2_hi[d]    = g_p_q[d][61:18];
      d2_lo[d]    = {g_p_q[d][17:0], 16'h0000};
      d2_den[d]   = g_mid_q.den_a;
      d2_hi[d+3]  = g_p_q[d][61:18];
      d2_lo[d+3]  = {g_p_q[d][17:0], 16'h0000};
      d2_den[d+3] = g_mid_q.den_b;
    end
  end

  ntpd_div #(
    .HI_W   (DEL_HI_W),
    .LO_W   (DEL_Q_W),
    .DEN_W  (DEL_DEN_W),
    .LANES  (DEL_LANES),
    .SIDE_W (TAIL_W)
  ) u_delta_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (g_vld_q),
    .hi_i    (d2_hi),
    .lo_i    (d2_lo),
    .den_i   (d2_den),
    .side_i  (h_tail),
    .valid_o (d2_vld),
    .quo_o   (d2_quo),
    .ovf_o   (d2_ovf),
    .side_o  (d2_side)
  );

  // ---------------------------------------------------------------- final sums
  tail_t          t_tail;
  ntpd_pkg::out_t t_out;

  always_comb begin
    logic [5:0][33:0] dm;
    logic [32:0]      r;
    logic [5:0][31:0] nv;
    logic             sat;
    t_tail = tail_t'(d2_side);
    sat    = t_tail.sat;
    for (int l = 0; l < DEL_LANES; l++) begin
      // a zero denominator leaves that phase untouched
      if ((l < 3) ? t_tail.dz_a : t_tail.dz_b) begin
        dm[l] = '0;
      end else if (d2_ovf[l] || (d2_quo[l] > ntpd_pkg::DELTA_CAP)) begin
        dm[l] = ntpd_pkg::DELTA_CAP;
      end else begin
        dm[l] = d2_quo[l];
      end
    end
    for (int d = 0; d < 3; d++) begin
      // phase a moves toward b, phase b the opposite way
      r       = sat_add(t_tail.va[d], dm[d], t_tail.neg[d]);
      nv[d]   = r[31:0];
      sat     = sat | r[32];
      r       = sat_add(t_tail.vb[d], dm[d+3], ~t_tail.neg[d]);
      nv[d+3] = r[31:0];
      sat     = sat | r[32];
    end
    t_out.new_vel_a_x = nv[0];
    t_out.new_vel_a_y = nv[1];
    t_out.new_vel_a_z = nv[2];
    t_out.new_vel_b_x = nv[3];
    t_out.new_vel_b_y = nv[4];
    t_out.new_vel_b_z = nv[5];
    t_out.saturated   = sat;
  end

  // ---------------------------------------------------------------- output buffer
  ntpd_pkg::out_t fifo_q [2];
  logic           wr_q;
  logic           rd_q;
  logic           push;
  logic           pop;

  assign push        = adv & d2_vld;
  assign out_valid_o = fifo_cnt_q != 2'd0;
  assign pop         = out_valid_o & out_ready_i;
  assign out_data_o  = fifo_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q       <= 1'b0;
      rd_q       <= 1'b0;
      fifo_cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      case ({push, pop})
        2'b10:   fifo_cnt_q <= fifo_cnt_q + 2'd1;
        2'b01:   fifo_cnt_q <= fifo_cnt_q - 2'd1;
        default: fifo_cnt_q <= fifo_cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= t_out;
    end
  end

endmodule
